// ===== rtl/core/acs_pkg.sv =====
// Shared widths, register codes and helper functions for the asinh color stretch core.
// No dependencies; every other file in rtl/core imports this package.
package acs_pkg;

	localparam int FLUX_W      = 32;
	localparam int FLUX_FRAC   = 24;
	localparam int S_W         = FLUX_W + 2;
	localparam int AMP_W       = 32;
	localparam int Q_W         = S_W + AMP_W - FLUX_FRAC;
	localparam int X_HALF      = (Q_W + 1) / 2;
	localparam int SQ_OP_W     = 2 * Q_W + 6;
	localparam int ROOT_W      = SQ_OP_W / 2;
	localparam int SQ_REM_W    = ROOT_W + 3;
	localparam int Y_W         = Q_W + 2;
	localparam int P_W         = 6;
	localparam int M_W         = 31;
	localparam int LOG_FRAC    = 16;
	localparam int LG_INT_W    = 5;
	localparam int LG_W        = LG_INT_W + LOG_FRAC;
	localparam int LOG_LAT     = LOG_FRAC + 2;
	localparam int F_W         = 23;
	localparam int MF_W        = F_W + 10;
	localparam int PROD_W      = MF_W + FLUX_W;
	localparam int NUM_W       = PROD_W - 16;
	localparam int OUT_W       = 8;
	localparam int LANE_LAT    = OUT_W + 2;
	localparam int LHS_W       = F_W + 2 + FLUX_W;
	localparam int DIV3_CHUNK  = 7;
	localparam int DIV3_STAGES = Q_W / DIV3_CHUNK;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 32;

	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLIFICATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH_MODE  = 2'd1;

	localparam logic [AMP_W-1:0] AMP_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [FLUX_W-1:0] c_r;
		logic [FLUX_W-1:0] c_g;
		logic [FLUX_W-1:0] c_b;
		logic [S_W-1:0]    s;
		logic [FLUX_W-1:0] cmax;
	} sideband_t;

	// Long division of a chunk of bits by three, carrying a two-bit remainder.
	// Returns the quotient bits above the new remainder.
	function automatic logic [DIV3_CHUNK+1:0] div3_chunk(input logic [1:0] rem_in,
		input logic [DIV3_CHUNK-1:0] bits);
		logic [2:0] r;
		logic [DIV3_CHUNK-1:0] q;
		r = {1'b0, rem_in};
		q = '0;
		for (int j = DIV3_CHUNK - 1; j >= 0; j--) begin
			r = {r[1:0], bits[j]};
			if (r >= 3'd3) begin
				r = r - 3'd3;
				q[j] = 1'b1;
			end
		end
		return {q, r[1:0]};
	endfunction

endpackage

// ===== rtl/core/acs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on acs_pkg for operand and root widths.
module acs_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [acs_pkg::SQ_OP_W-1:0] operand,
	output logic [acs_pkg::ROOT_W-1:0]  root
);
	import acs_pkg::*;

	logic [SQ_OP_W-1:0]  op_s   [ROOT_W];
	logic [SQ_REM_W-1:0] rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];

	logic [SQ_OP_W-1:0]  op_prev   [ROOT_W];
	logic [SQ_REM_W-1:0] rem_prev  [ROOT_W];
	logic [ROOT_W-1:0]   root_prev [ROOT_W];
	logic [SQ_REM_W-1:0] rem_in    [ROOT_W];
	logic [SQ_REM_W-1:0] trial     [ROOT_W];

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				op_prev[k]   = operand;
				rem_prev[k]  = '0;
				root_prev[k] = '0;
			end else begin
				op_prev[k]   = op_s[k-1];
				rem_prev[k]  = rem_s[k-1];
				root_prev[k] = root_s[k-1];
			end
			// Bring down the next two operand bits and try root*4+1.
			rem_in[k] = {rem_prev[k][SQ_REM_W-3:0], op_prev[k][SQ_OP_W-1 -: 2]};
			trial[k]  = {1'b0, root_prev[k], 2'b01};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				op_s[k] <= op_prev[k] << 2;
				if (rem_in[k] >= trial[k]) begin
					rem_s[k]  <= rem_in[k] - trial[k];
					root_s[k] <= {root_prev[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_in[k];
					root_s[k] <= {root_prev[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

// ===== rtl/core/acs_log.sv =====
// Pipelined natural log in Q5.16: leading-one normalize, sixteen squaring
// stages for the fraction of log2, then a scale by ln 2. Depends on acs_pkg.
module acs_log (
	input  logic                   clk,
	input  logic                   en,
	input  logic [acs_pkg::Y_W-1:0]  y,
	output logic [acs_pkg::LG_W-1:0] f
);
	import acs_pkg::*;

	logic [P_W-1:0]      p_c;
	logic [Y_W+29:0]     y_ext;
	logic [M_W-1:0]      m_c;

	logic [P_W-1:0]      p_s  [LOG_FRAC+1];
	logic [M_W-1:0]      m_s  [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] fr_s [LOG_FRAC+1];

	logic [2*M_W-1:0]    sq_c [LOG_FRAC+1];
	logic [M_W:0]        sh_c [LOG_FRAC+1];

	logic [LG_W-1:0]     lg_c;
	logic [LG_W+63:0]    scaled_c;
	logic [LG_W-1:0]     f_q;

	always_comb begin
		p_c = '0;
		for (int j = 0; j < Y_W; j++) begin
			if (y[j]) begin
				p_c = P_W'(j);
			end
		end
		// Mantissa in Q30: y * 2^30 / 2^p, truncated.
		y_ext = {y, 30'b0};
		m_c   = M_W'(y_ext >> p_c);
	end

	always_comb begin
		sq_c[0] = '0;
		sh_c[0] = '0;
		for (int k = 1; k <= LOG_FRAC; k++) begin
			sq_c[k] = m_s[k-1] * m_s[k-1];
			sh_c[k] = sq_c[k][2*M_W-1:30];
		end
		lg_c     = {LG_INT_W'(p_s[LOG_FRAC] - P_W'(LOG_FRAC)), fr_s[LOG_FRAC]};
		scaled_c = (LG_W + 64)'(lg_c) * (LG_W + 64)'(LN2_Q32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0]  <= p_c;
			m_s[0]  <= m_c;
			fr_s[0] <= '0;
			for (int k = 1; k <= LOG_FRAC; k++) begin
				p_s[k] <= p_s[k-1];
				if (sh_c[k][M_W]) begin
					m_s[k]  <= sh_c[k][M_W:1];
					fr_s[k] <= fr_s[k-1] | (LOG_FRAC'(1) << (LOG_FRAC - k));
				end else begin
					m_s[k]  <= sh_c[k][M_W-1:0];
					fr_s[k] <= fr_s[k-1];
				end
			end
			f_q <= scaled_c[LG_W+31:32];
		end
	end

	assign f = f_q;

endmodule

// ===== rtl/core/acs_lane.sv =====
// One color lane: scales its channel by the stretch factor or by 1/cmax and
// divides down to a byte with an eight-stage restoring divider. Depends on acs_pkg.
module acs_lane (
	input  logic                      clk,
	input  logic                      en,
	input  logic [acs_pkg::F_W-1:0]    f,
	input  logic [acs_pkg::FLUX_W-1:0] c,
	input  logic [acs_pkg::FLUX_W-1:0] cmax,
	input  logic [acs_pkg::S_W-1:0]    s,
	input  logic                      clamp,
	output logic [acs_pkg::OUT_W-1:0]  q
);
	import acs_pkg::*;

	logic [MF_W-1:0]   m765_c;
	logic [PROD_W-1:0] prod_s1;
	logic [FLUX_W-1:0] c_s1;
	logic [FLUX_W-1:0] cmax_s1;
	logic [S_W-1:0]    s_s1;
	logic              zero_s1;

	logic [NUM_W-1:0]  num_s2;
	logic [S_W-1:0]    den_s2;
	logic              zero_s2;

	logic [NUM_W-1:0]  n_d [OUT_W];
	logic [S_W-1:0]    d_d [OUT_W];
	logic [OUT_W-1:0]  q_d [OUT_W];
	logic              z_d [OUT_W];

	logic [NUM_W-1:0]  n_prev [OUT_W];
	logic [S_W-1:0]    d_prev [OUT_W];
	logic [OUT_W-1:0]  q_prev [OUT_W];
	logic              z_prev [OUT_W];
	logic [NUM_W-1:0]  t_c    [OUT_W];

	assign m765_c = MF_W'(f) * MF_W'(765);

	always_comb begin
		for (int k = 0; k < OUT_W; k++) begin
			if (k == 0) begin
				n_prev[k] = num_s2;
				d_prev[k] = den_s2;
				q_prev[k] = '0;
				z_prev[k] = zero_s2;
			end else begin
				n_prev[k] = n_d[k-1];
				d_prev[k] = d_d[k-1];
				q_prev[k] = q_d[k-1];
				z_prev[k] = z_d[k-1];
			end
			t_c[k] = NUM_W'(d_prev[k]) << (OUT_W - 1 - k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(m765_c) * PROD_W'(c);
			c_s1    <= c;
			cmax_s1 <= cmax;
			s_s1    <= s;
			zero_s1 <= (s == '0);

			// The quotient is below 256 on both paths, so eight steps suffice.
			if (clamp) begin
				num_s2 <= NUM_W'({c_s1, 8'b0}) - NUM_W'(c_s1);
				den_s2 <= S_W'(cmax_s1);
			end else begin
				num_s2 <= prod_s1[PROD_W-1:16];
				den_s2 <= s_s1;
			end
			zero_s2 <= zero_s1;

			for (int k = 0; k < OUT_W; k++) begin
				d_d[k] <= d_prev[k];
				z_d[k] <= z_prev[k];
				if (n_prev[k] >= t_c[k]) begin
					n_d[k] <= n_prev[k] - t_c[k];
					q_d[k] <= {q_prev[k][OUT_W-2:0], 1'b1};
				end else begin
					n_d[k] <= n_prev[k];
					q_d[k] <= {q_prev[k][OUT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign q = z_d[OUT_W-1] ? '0 : q_d[OUT_W-1];

endmodule

// ===== rtl/core/asinh_color_stretch_pixel_core.sv =====
// Asinh color stretch pixel core.
// Throughput one pixel per cycle; the whole pipeline holds while an output beat waits.
// The depth is set by the two 45-stage square root pipelines (asinh operand, then the
// second root of power mode, matched by the log path) and the 8-stage lane dividers.
// Reset clears all valid flags and loads amplification 1.0 and asinh mode.
// Depends on acs_pkg, acs_sqrt, acs_log and acs_lane.
module asinh_color_stretch_pixel_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [95:0]                  s_tdata,   // flux_red, flux_green, flux_blue
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // out_red, out_green, out_blue
	input  logic                         cfg_we,
	input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acs_pkg::CFG_W-1:0]     cfg_data
);
	import acs_pkg::*;

	localparam int ST_D3_IN   = 2;
	localparam int ST_SQ_IN   = ST_D3_IN + DIV3_STAGES + 2;
	localparam int ST_R1      = ST_SQ_IN + ROOT_W;
	localparam int ST_LOG_OUT = ST_R1 + LOG_LAT;
	localparam int ST_F_IN    = ST_R1 + ROOT_W;
	localparam int PAD_LEN    = ST_F_IN - ST_LOG_OUT;
	localparam int ST_G       = ST_F_IN + 1;
	localparam int ST_LHS     = ST_G + 1;
	localparam int ST_OUT     = ST_G + LANE_LAT + 1;

	logic             en;
	logic [AMP_W-1:0] amp_q;
	logic             mode_q;
	logic             v_q [ST_OUT+1];

	sideband_t        sb_c;
	sideband_t        sb_q [ST_LHS+1];

	logic [49:0]      ph_s1;
	logic [47:0]      pl_s1;
	logic [65:0]      p_c;

	logic [Q_W-1:0]   d3w_s [DIV3_STAGES+1];
	logic [1:0]       d3r_s [DIV3_STAGES+1];
	logic [DIV3_CHUNK+1:0] d3c [DIV3_STAGES];
	logic [Q_W-1:0]   d3n [DIV3_STAGES];

	logic [Q_W-1:0]   x_c;
	logic [2*X_HALF-1:0] hh_s9, hl_s9, ll_s9;
	logic [Q_W-1:0]   x_s9;
	logic [SQ_OP_W-1:0] op_s10;
	logic [Q_W-1:0]   xd_s [ROOT_W+1];

	logic [ROOT_W-1:0] r1;
	logic [ROOT_W-1:0] r2;
	logic [Y_W-1:0]    y_c;
	logic [LG_W-1:0]   f_log;
	logic [LG_W-1:0]   lp_s [PAD_LEN];

	logic [F_W-1:0]    f_s101;
	logic [LHS_W-1:0]  lhs_s102;
	logic              clamp_c;
	logic [OUT_W-1:0]  q_r, q_g, q_b;
	logic [23:0]       out_s112;

	assign en       = !v_q[ST_OUT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[ST_OUT];
	assign m_tdata  = out_s112;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q  <= AMP_RESET;
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AMPLIFICATION: amp_q  <= cfg_data[AMP_W-1:0];
				REG_STRETCH_MODE:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ST_OUT; k++) begin
				v_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= s_tvalid;
			for (int k = 1; k <= ST_OUT; k++) begin
				v_q[k] <= v_q[k-1];
			end
		end
	end

	always_comb begin
		sb_c.c_r  = s_tdata[FLUX_W-1:0];
		sb_c.c_g  = s_tdata[2*FLUX_W-1:FLUX_W];
		sb_c.c_b  = s_tdata[3*FLUX_W-1:2*FLUX_W];
		sb_c.s    = S_W'(sb_c.c_r) + S_W'(sb_c.c_g) + S_W'(sb_c.c_b);
		sb_c.cmax = sb_c.c_r;
		if (sb_c.c_g > sb_c.cmax) begin
			sb_c.cmax = sb_c.c_g;
		end
		if (sb_c.c_b > sb_c.cmax) begin
			sb_c.cmax = sb_c.c_b;
		end
	end

	// Intensity times gain, divided by 3 * 2^24 as a shift and a chunked divide by three.
	assign p_c = (66'(ph_s1) << 16) + 66'(pl_s1);

	always_comb begin
		for (int k = 0; k < DIV3_STAGES; k++) begin
			d3c[k] = div3_chunk(d3r_s[k],
				d3w_s[k][Q_W-1-DIV3_CHUNK*k -: DIV3_CHUNK]);
			d3n[k] = d3w_s[k];
			d3n[k][Q_W-1-DIV3_CHUNK*k -: DIV3_CHUNK] = d3c[k][DIV3_CHUNK+1:2];
		end
	end

	assign x_c = d3w_s[DIV3_STAGES];
	assign y_c = Y_W'(xd_s[ROOT_W]) + Y_W'(r1);

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q[0] <= sb_c;
			for (int k = 1; k <= ST_LHS; k++) begin
				sb_q[k] <= sb_q[k-1];
			end

			pl_s1 <= 48'(sb_q[0].s[15:0]) * 48'(amp_q);
			ph_s1 <= 50'(sb_q[0].s[S_W-1:16]) * 50'(amp_q);

			d3w_s[0] <= p_c[65:24];
			d3r_s[0] <= 2'd0;
			for (int k = 0; k < DIV3_STAGES; k++) begin
				d3w_s[k+1] <= d3n[k];
				d3r_s[k+1] <= d3c[k][1:0];
			end

			x_s9  <= x_c;
			hh_s9 <= (2*X_HALF)'(x_c[Q_W-1:X_HALF]) * (2*X_HALF)'(x_c[Q_W-1:X_HALF]);
			hl_s9 <= (2*X_HALF)'(x_c[Q_W-1:X_HALF]) * (2*X_HALF)'(x_c[X_HALF-1:0]);
			ll_s9 <= (2*X_HALF)'(x_c[X_HALF-1:0]) * (2*X_HALF)'(x_c[X_HALF-1:0]);

			// Asinh needs sqrt(x^2 + 1.0^2); power mode needs sqrt(x * 2^48).
			if (mode_q) begin
				op_s10 <= (SQ_OP_W'(hh_s9) << (2 * X_HALF))
					+ (SQ_OP_W'(hl_s9) << (X_HALF + 1))
					+ SQ_OP_W'(ll_s9) + (SQ_OP_W'(1) << 32);
			end else begin
				op_s10 <= {x_s9, 48'b0};
			end
			xd_s[0] <= x_s9;
			for (int k = 1; k <= ROOT_W; k++) begin
				xd_s[k] <= xd_s[k-1];
			end

			lp_s[0] <= f_log;
			for (int k = 1; k < PAD_LEN; k++) begin
				lp_s[k] <= lp_s[k-1];
			end

			f_s101   <= mode_q ? F_W'(lp_s[PAD_LEN-1]) : r2[F_W-1:0];
			lhs_s102 <= LHS_W'((F_W + 2)'(f_s101) * (F_W + 2)'(3))
				* LHS_W'(sb_q[ST_G].cmax);
			out_s112 <= {q_b, q_g, q_r};
		end
	end

	acs_sqrt u_sqrt_a (
		.clk     (clk),
		.en      (en),
		.operand (op_s10),
		.root    (r1)
	);

	acs_sqrt u_sqrt_b (
		.clk     (clk),
		.en      (en),
		.operand (SQ_OP_W'(r1)),
		.root    (r2)
	);

	acs_log u_log (
		.clk (clk),
		.en  (en),
		.y   (y_c),
		.f   (f_log)
	);

	// Scaled channels overflow one when 3 * f * cmax exceeds S in Q16.
	assign clamp_c = lhs_s102 > LHS_W'({sb_q[ST_LHS].s, 16'b0});

	acs_lane u_lane_r (
		.clk (clk), .en (en), .f (f_s101), .c (sb_q[ST_G].c_r),
		.cmax (sb_q[ST_G].cmax), .s (sb_q[ST_G].s), .clamp (clamp_c), .q (q_r)
	);

	acs_lane u_lane_g (
		.clk (clk), .en (en), .f (f_s101), .c (sb_q[ST_G].c_g),
		.cmax (sb_q[ST_G].cmax), .s (sb_q[ST_G].s), .clamp (clamp_c), .q (q_g)
	);

	acs_lane u_lane_b (
		.clk (clk), .en (en), .f (f_s101), .c (sb_q[ST_G].c_b),
		.cmax (sb_q[ST_G].cmax), .s (sb_q[ST_G].s), .clamp (clamp_c), .q (q_b)
	);

	// The asinh stretch of a 42-bit intensity stays below 32.0 in Q16.
	a_asinh_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_G] && mode_q |-> f_s101[F_W-1:F_W-2] == 2'b00)
		else $error("asinh stretch value out of range");

	// Black pixels must reach the lanes with a zero stretch in either mode.
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_G] && sb_q[ST_G].s == '0 |-> f_s101 == '0)
		else $error("nonzero stretch for zero flux");

	// Renormalizing by cmax only happens for a nonzero stretch.
	a_clamp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_LHS] && clamp_c |-> lhs_s102 != '0 && sb_q[ST_LHS].cmax != '0)
		else $error("clamp path taken without stretch");

endmodule

// ===== tb/tb_asinh_color_stretch_pixel_core.sv =====
// Self-checking testbench for asinh_color_stretch_pixel_core: a bit-exact predictor of the
// stretch computes each pixel's bytes as its input beat is accepted.
// Depends on acs_pkg and the core RTL.
module tb_asinh_color_stretch_pixel_core;
	timeunit 1ns;
	timeprecision 1ps;
	import acs_pkg::*;

	localparam int LATENCY = 113;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [63:0] LN2_FACTOR = 64'd2977044472;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [31:0] amp_gain;
	logic asinh_sel;
	logic [23:0] pixel_q[$];
	int errors;
	int quiet_cycles;
	bit no_idle;
	int stall_left;

	asinh_color_stretch_pixel_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] isqrt(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= n)
				r = t;
		end
		return r;
	endfunction

	// Natural log in Q16.16 of a Q16.16 value of at least one.
	function automatic logic [63:0] ln_fixed(input logic [63:0] y);
		int p;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] lg;
		p = 63;
		while (p > 0 && !y[p])
			p--;
		m = (p >= 30) ? (y >> (p - 30)) : (y << (30 - p));
		frac = '0;
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[k] = 1'b1;
			end
		end
		lg = (64'(p - 16) << 16) | frac;
		return (lg * LN2_FACTOR) >> 32;
	endfunction

	function automatic logic [23:0] stretch_pixel(input logic [95:0] flux);
		logic [63:0] chan[3];
		logic [63:0] sum;
		logic [63:0] cmax;
		logic [63:0] x;
		logic [63:0] f;
		logic [63:0] root;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [127:0] v;
		logic [23:0] res;
		for (int k = 0; k < 3; k++)
			chan[k] = 64'(flux[32*k +: 32]);
		sum = chan[0] + chan[1] + chan[2];
		if (sum == 0)
			return '0;
		cmax = chan[0];
		if (chan[1] > cmax) cmax = chan[1];
		if (chan[2] > cmax) cmax = chan[2];
		x = 64'((128'(sum) * 128'(amp_gain)) / (128'd3 << 24));
		if (asinh_sel) begin
			root = isqrt(128'(x) * 128'(x) + (128'd1 << 32));
			f = ln_fixed(x + root);
		end else begin
			root = isqrt(128'(x) << 48);
			f = isqrt(128'(root));
		end
		lhs = 128'(3 * f) * 128'(cmax);
		rhs = 128'(sum) << 16;
		for (int k = 0; k < 3; k++) begin
			if (lhs > rhs)
				v = (128'd255 * 128'(chan[k])) / 128'(cmax);
			else
				v = ((128'(765 * f) * 128'(chan[k])) >> 16) / 128'(sum);
			res[8*k +: 8] = (v > 255) ? 8'd255 : v[7:0];
		end
		return res;
	endfunction

	// Input beats are predicted as they are accepted; output beats are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pixel_q.push_back(stretch_pixel(s_tdata));
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$error("output beat %h with no pixel pending", m_tdata);
					errors++;
				end else begin
					logic [23:0] want;
					want = pixel_q.pop_front();
					if (m_tdata[7:0] !== want[7:0]) begin
						$error("out_red expected %0d actual %0d", want[7:0], m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== want[15:8]) begin
						$error("out_green expected %0d actual %0d", want[15:8], m_tdata[15:8]);
						errors++;
					end
					if (m_tdata[23:16] !== want[23:16]) begin
						$error("out_blue expected %0d actual %0d", want[23:16], m_tdata[23:16]);
						errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Output back-pressure: mostly ready, short stalls and now and then a long one.
	always @(posedge clk) begin
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			int pick;
			pick = $urandom_range(99);
			if (pick < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left <= (pick < 95) ? $urandom_range(2) : $urandom_range(40, 10);
			end
		end
	end

	function automatic int pick_gap();
		int pick;
		if (no_idle)
			return 0;
		pick = $urandom_range(99);
		if (pick < 60) return 0;
		if (pick < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic send_pixel(input logic [31:0] red, input logic [31:0] green,
		input logic [31:0] blue);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {blue, green, red};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only once the pipeline has drained.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_AMPLIFICATION)
			amp_gain = value;
		else if (index == REG_STRETCH_MODE)
			asinh_sel = value[0];
	endtask

	function automatic logic [31:0] rand_flux();
		case ($urandom_range(5))
			0: return $urandom_range(255);
			1: return $urandom & 32'h00FF_FFFF;
			2: return $urandom & 32'h0FFF_FFFF;
			3: return 32'hFFFF_FFFF - $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_pixels(input int count);
		logic [31:0] c[3];
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++)
				c[k] = rand_flux();
			case ($urandom_range(9))
				0: c[$urandom_range(2)] = '0;
				1: begin
					c[1] = c[0];
					c[2] = c[0];
				end
				2: c = '{32'd0, 32'd0, 32'd0};
				default: ;
			endcase
			send_pixel(c[0], c[1], c[2]);
		end
		end_stream();
	endtask

	task automatic test_directed();
		send_pixel(32'd0, 32'd0, 32'd0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'd1, 32'd0, 32'd0);
		send_pixel(32'd0, 32'd0, 32'd2);
		send_pixel(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
		send_pixel(32'h0100_0000, 32'd0, 32'd0);
		send_pixel(32'hFFFF_FFFF, 32'd0, 32'd1);
		send_pixel(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		send_pixel(32'h8000_0000, 32'h0000_0001, 32'h4000_0000);
		send_pixel(32'h0000_0100, 32'h0000_0200, 32'h0000_0300);
		send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		end_stream();
	endtask

	task automatic test_asinh_mode();
		write_reg(REG_STRETCH_MODE, 32'd1);
		write_reg(REG_AMPLIFICATION, 32'h0004_0000);
		random_pixels(150);
	endtask

	task automatic test_power_mode();
		write_reg(REG_STRETCH_MODE, 32'd0);
		test_directed();
		write_reg(REG_AMPLIFICATION, 32'h0000_0100);
		random_pixels(150);
	endtask

	task automatic test_gain_extremes();
		write_reg(REG_AMPLIFICATION, 32'd0);
		test_directed();
		write_reg(REG_AMPLIFICATION, 32'hFFFF_FFFF);
		test_directed();
		write_reg(REG_STRETCH_MODE, 32'hFFFF_FFFE);
		test_directed();
		random_pixels(60);
	endtask

	task automatic test_random_gain();
		for (int phase = 0; phase < 4; phase++) begin
			no_idle = (phase == 2);
			write_reg(REG_STRETCH_MODE, $urandom);
			write_reg(REG_AMPLIFICATION, $urandom);
			random_pixels(50);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		amp_gain = 32'h0001_0000;
		asinh_sel = 1'b1;
		errors = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		stall_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_asinh_mode();
		test_power_mode();
		test_gain_extremes();
		test_random_gain();

		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
